// File: sv/cetm_pkg.sv
package cetm_pkg;

    // Widths of the configured date and time fields.
    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;

    // Widest value a token can be compared against (the minute field).
    localparam int VAL_W     = 6;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = YEAR_W;

    localparam int FIELD_COUNT = 5;

    // Depth of the weekday pipeline and the width of its settle counter.
    localparam int WD_STAGES = 5;
    localparam int WD_CNT_W  = 3;

    // Queue between the classifier and the token sequencer.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_YEAR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MONTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUTE = 3'd4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        CC_SPACE,
        CC_STAR,
        CC_SLASH,
        CC_DIGIT,
        CC_OTHER
    } t_char_cls;

    typedef struct packed {
        t_char_cls  cls;
        logic [3:0] digit;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } t_cfg;

    // Month term of the weekday formula, indexed by month minus one.
    function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] idx);
        logic [2:0] off;
        begin
            unique case (idx)
                4'd0:    off = 3'd0;
                4'd1:    off = 3'd3;
                4'd2:    off = 3'd2;
                4'd3:    off = 3'd5;
                4'd4:    off = 3'd0;
                4'd5:    off = 3'd3;
                4'd6:    off = 3'd5;
                4'd7:    off = 3'd1;
                4'd8:    off = 3'd4;
                4'd9:    off = 3'd6;
                4'd10:   off = 3'd2;
                4'd11:   off = 3'd4;
                default: off = 3'd0;
            endcase
            return off;
        end
    endfunction

endpackage

// File: sv/cetm_front.sv
module cetm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_valid,
    output logic            o_s_ready,
    input  logic [7:0]      i_s_char,
    input  logic            i_s_last,
    output logic            o_item_valid,
    input  logic            i_item_ready,
    output cetm_pkg::t_item o_item
);
    import cetm_pkg::*;

    t_item w_item;
    logic  r_valid;
    t_item r_item;

    always_comb begin
        w_item.last  = i_s_last;
        w_item.digit = 4'd0;
        if (i_s_char == CH_SPACE) begin
            w_item.cls = CC_SPACE;
        end else if (i_s_char == CH_STAR) begin
            w_item.cls = CC_STAR;
        end else if (i_s_char == CH_SLASH) begin
            w_item.cls = CC_SLASH;
        end else if (i_s_char >= CH_ZERO && i_s_char <= CH_NINE) begin
            w_item.cls   = CC_DIGIT;
            w_item.digit = 4'(i_s_char - CH_ZERO);
        end else begin
            w_item.cls = CC_OTHER;
        end
    end

    assign o_s_ready    = !r_valid || i_item_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_ready) begin
            r_valid <= i_s_valid;
        end
        if (i_s_valid && o_s_ready) begin
            r_item <= w_item;
        end
    end

endmodule

// File: sv/cetm_fifo.sv
module cetm_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_in_ready,
    input  cetm_pkg::t_item i_data,
    output logic            o_out_valid,
    input  logic            i_pop,
    output cetm_pkg::t_item o_data
);
    import cetm_pkg::*;

    t_item                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_CW-1:0]   r_count;
    logic                 w_do_push;
    logic                 w_do_pop;

    assign o_in_ready  = r_count != FIFO_CW'(FIFO_DEPTH);
    assign o_out_valid = r_count != '0;
    assign o_data      = r_mem[r_rd];
    assign w_do_push   = i_push && o_in_ready;
    assign w_do_pop    = i_pop && o_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: sv/cetm_weekday.sv
module cetm_weekday (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_restart,
    input  cetm_pkg::t_cfg i_cfg,
    output logic [2:0]     o_weekday,
    output logic           o_ok
);
    import cetm_pkg::*;

    localparam int Y_W   = YEAR_W + 1;
    localparam int P1_W  = Y_W + 13;
    localparam int P2_W  = 32;

    logic [Y_W-1:0]       w_y;
    logic [P1_W-1:0]      w_p100;
    logic [P2_W-1:0]      w_p7;
    logic [Y_W-1:0]       w_sum;
    logic [Y_W-1:0]       w_q7x7;

    logic [Y_W-1:0]       r_y1;
    logic [2:0]           r_t1;
    logic [DAY_W-1:0]     r_d1;
    logic [Y_W-1:0]       r_y2;
    logic [7:0]           r_q100;
    logic [2:0]           r_t2;
    logic [DAY_W-1:0]     r_d2;
    logic [Y_W-1:0]       r_sum3;
    logic [Y_W-1:0]       r_sum4;
    logic [11:0]          r_q7;
    logic [2:0]           r_wd;
    logic [WD_CNT_W-1:0]  r_settle;

    // January and February count toward the previous year; 400 is added so
    // that year zero stays positive without changing the weekday.
    assign w_y = Y_W'(i_cfg.year) + Y_W'(400)
               - ((i_cfg.month < 4'd3) ? Y_W'(1) : Y_W'(0));

    // y / 100 as a reciprocal multiply, exact over the whole year range.
    assign w_p100 = P1_W'(r_y1) * P1_W'(5243);

    assign w_sum = r_y2 + (r_y2 >> 2) - Y_W'(r_q100) + Y_W'(r_q100 >> 2)
                 + Y_W'(r_t2) + Y_W'(r_d2);

    // sum / 7 as a reciprocal multiply, exact for sums below 2**15.
    assign w_p7   = P2_W'(r_sum3) * P2_W'(74899);
    assign w_q7x7 = (Y_W'(r_q7) << 3) - Y_W'(r_q7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= WD_CNT_W'(WD_STAGES);
        end else if (i_restart) begin
            r_settle <= WD_CNT_W'(WD_STAGES);
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 1'b1;
        end
        r_y1   <= w_y;
        r_t1   <= month_offset(i_cfg.month - 1'b1);
        r_d1   <= i_cfg.day;
        r_y2   <= r_y1;
        r_q100 <= w_p100[26:19];
        r_t2   <= r_t1;
        r_d2   <= r_d1;
        r_sum3 <= w_sum;
        r_sum4 <= r_sum3;
        r_q7   <= w_p7[30:19];
        r_wd   <= 3'(r_sum4 - w_q7x7);
    end

    assign o_weekday = r_wd;
    assign o_ok      = r_settle == '0;

endmodule

// File: sv/cetm_back.sv
module cetm_back #(
    parameter int ACC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    output logic            o_item_ready,
    input  cetm_pkg::t_item i_item,
    input  cetm_pkg::t_cfg  i_cfg,
    input  logic [2:0]      i_wd,
    input  logic            i_wd_ok,
    output logic            o_m_valid,
    input  logic            i_m_ready,
    output logic            o_m_match
);
    import cetm_pkg::*;

    typedef enum logic [2:0] {
        PH_BETWEEN,
        PH_STAR,
        PH_STAR_SLASH,
        PH_STEP,
        PH_NUM,
        PH_SEP,
        PH_BAD,
        PH_DONE
    } t_phase;

    typedef enum logic {
        ST_RUN,
        ST_MOD
    } t_state;

    t_state                r_state;
    logic [2:0]            r_field;
    t_phase                r_phase;
    logic [ACC_BITS-1:0]   r_acc;
    logic                  r_failed;
    logic [2:0]            r_weekday;
    logic [VAL_W-1:0]      r_mod_rem;
    logic [VAL_W-1:0]      r_mod_val;
    logic [VAL_W-1:0]      r_mod_div;
    logic [2:0]            r_mod_cnt;
    logic                  r_mod_last;
    logic                  r_out_valid;
    logic                  r_out_match;

    logic [VAL_W-1:0]      w_val;
    logic [ACC_BITS+3:0]   w_acc_x10;
    logic [ACC_BITS-1:0]   w_acc_dig;
    t_phase                w_phase;
    logic [ACC_BITS-1:0]   w_acc;
    logic                  w_open;
    logic                  w_fin;
    logic                  w_fin_ok;
    logic                  w_fin_mod;
    logic [2:0]            w_field_after;
    logic                  w_failed_after;
    logic                  w_at_start;
    logic                  w_pop;
    logic [VAL_W:0]        w_rem_sh;
    logic [VAL_W-1:0]      w_rem_next;
    logic                  w_mod_ok;
    logic [2:0]            w_mod_field;
    logic                  w_mod_failed;
    logic                  w_out_set;

    always_comb begin
        unique case (r_field)
            3'd0:    w_val = i_cfg.minute;
            3'd1:    w_val = VAL_W'(i_cfg.hour);
            3'd2:    w_val = VAL_W'(i_cfg.day);
            3'd3:    w_val = VAL_W'(i_cfg.month);
            default: w_val = VAL_W'(r_weekday);
        endcase
    end

    // Decimal accumulate with saturation at the all-ones value.
    assign w_acc_x10 = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1)
                     + {{ACC_BITS{1'b0}}, i_item.digit};
    assign w_acc_dig = (w_acc_x10[ACC_BITS+3:ACC_BITS] != 4'd0) ? {ACC_BITS{1'b1}}
                                                                : w_acc_x10[ACC_BITS-1:0];

    assign w_open = r_field < 3'(FIELD_COUNT);

    // Effect of one character on the token scanner.
    always_comb begin
        w_phase = r_phase;
        w_acc   = r_acc;
        w_fin   = 1'b0;
        if (w_open) begin
            if (i_item.cls == CC_SPACE) begin
                w_fin = r_phase != PH_BETWEEN;
            end else begin
                unique case (r_phase)
                    PH_BETWEEN: begin
                        if (i_item.cls == CC_STAR) begin
                            w_phase = PH_STAR;
                        end else if (i_item.cls == CC_DIGIT) begin
                            w_phase = PH_NUM;
                            w_acc   = ACC_BITS'(i_item.digit);
                        end else begin
                            w_phase = PH_BAD;
                        end
                    end
                    PH_STAR: begin
                        w_phase = (i_item.cls == CC_SLASH) ? PH_STAR_SLASH : PH_BAD;
                    end
                    PH_STAR_SLASH, PH_SEP: begin
                        if (i_item.cls == CC_DIGIT) begin
                            w_phase = (r_phase == PH_SEP) ? PH_NUM : PH_STEP;
                            w_acc   = ACC_BITS'(i_item.digit);
                        end else begin
                            w_phase = PH_BAD;
                        end
                    end
                    PH_STEP: begin
                        if (i_item.cls == CC_DIGIT) begin
                            w_acc = w_acc_dig;
                        end else begin
                            w_phase = PH_BAD;
                        end
                    end
                    PH_NUM: begin
                        if (i_item.cls == CC_DIGIT) begin
                            w_acc = w_acc_dig;
                        end else begin
                            w_phase = (r_acc == ACC_BITS'(w_val)) ? PH_DONE : PH_SEP;
                        end
                    end
                    PH_BAD, PH_DONE: begin
                    end
                endcase
            end
            // The last character closes a token that is still open.
            if (!w_fin && i_item.last && w_phase != PH_BETWEEN) begin
                w_fin = 1'b1;
            end
        end
    end

    // Verdict of a closing token; a step token with a small divisor goes
    // to the remainder sequencer instead.
    always_comb begin
        w_fin_ok  = 1'b0;
        w_fin_mod = 1'b0;
        unique case (w_phase)
            PH_STAR, PH_DONE: w_fin_ok = 1'b1;
            PH_NUM:           w_fin_ok = w_acc == ACC_BITS'(w_val);
            PH_STEP: begin
                if (w_acc == '0) begin
                    w_fin_ok = 1'b0;
                end else if (w_acc[ACC_BITS-1:VAL_W] != '0) begin
                    w_fin_ok = w_val == '0;
                end else begin
                    w_fin_mod = 1'b1;
                end
            end
            default: w_fin_ok = 1'b0;
        endcase
    end

    assign w_field_after  = w_fin ? r_field + 3'd1 : r_field;
    assign w_failed_after = r_failed | (w_fin & ~w_fin_ok);
    assign w_at_start     = r_field == 3'd0 && r_phase == PH_BETWEEN;

    assign o_item_ready = r_state == ST_RUN && (!w_at_start || i_wd_ok)
                        && (!i_item.last || !r_out_valid || i_m_ready);
    assign w_pop        = i_item_valid && o_item_ready;

    // One restoring remainder step per cycle, most significant bit first.
    assign w_rem_sh     = {r_mod_rem, r_mod_val[VAL_W-1]};
    assign w_rem_next   = (w_rem_sh >= {1'b0, r_mod_div}) ? VAL_W'(w_rem_sh - {1'b0, r_mod_div})
                                                          : w_rem_sh[VAL_W-1:0];
    assign w_mod_ok     = w_rem_next == '0;
    assign w_mod_field  = r_field + 3'd1;
    assign w_mod_failed = r_failed | ~w_mod_ok;

    // A result is loaded on the last character, or when the remainder of a
    // step token closed by the last character is done.
    assign w_out_set = (r_state == ST_RUN && w_pop && i_item.last && !(w_fin && w_fin_mod))
                     || (r_state == ST_MOD && r_mod_cnt == 3'd0 && r_mod_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_field     <= 3'd0;
            r_phase     <= PH_BETWEEN;
            r_acc       <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_set) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_RUN: begin
                    if (w_pop) begin
                        if (w_at_start) begin
                            r_weekday <= i_wd;
                        end
                        if (w_fin && w_fin_mod) begin
                            r_state    <= ST_MOD;
                            r_phase    <= w_phase;
                            r_acc      <= w_acc;
                            r_mod_rem  <= '0;
                            r_mod_val  <= w_val;
                            r_mod_div  <= w_acc[VAL_W-1:0];
                            r_mod_cnt  <= 3'(VAL_W - 1);
                            r_mod_last <= i_item.last;
                        end else if (i_item.last) begin
                            r_out_match <= w_field_after == 3'(FIELD_COUNT) && !w_failed_after;
                            r_field     <= 3'd0;
                            r_phase     <= PH_BETWEEN;
                            r_acc       <= '0;
                            r_failed    <= 1'b0;
                        end else if (w_fin) begin
                            r_field  <= w_field_after;
                            r_failed <= w_failed_after;
                            r_phase  <= PH_BETWEEN;
                            r_acc    <= '0;
                        end else begin
                            r_phase <= w_phase;
                            r_acc   <= w_acc;
                        end
                    end
                end
                ST_MOD: begin
                    r_mod_rem <= w_rem_next;
                    r_mod_val <= r_mod_val << 1;
                    r_mod_cnt <= r_mod_cnt - 3'd1;
                    if (r_mod_cnt == 3'd0) begin
                        r_state <= ST_RUN;
                        r_phase <= PH_BETWEEN;
                        r_acc   <= '0;
                        if (r_mod_last) begin
                            r_out_match <= w_mod_field == 3'(FIELD_COUNT) && !w_mod_failed;
                            r_field     <= 3'd0;
                            r_failed    <= 1'b0;
                        end else begin
                            r_field  <= w_mod_field;
                            r_failed <= w_mod_failed;
                        end
                    end
                end
            endcase
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_match = r_out_match;

endmodule

// File: sv/cron_entry_time_match_unit.sv
// Each character is registered in the front end and queued before the sequencer takes it.
// The match bit of the last character is registered when it is taken, or when the bit-serial
// remainder is done if the last token is a step token with a divisor below 64. Throughput:
// one character per cycle, save while the sequencer works out such a remainder or waits on
// the result port, and a character that opens an entry waits after a register write while the
// weekday pipeline settles. Reset is synchronous, active low, and sets 2000-01-01 00:00.
module cron_entry_time_match_unit #(
    parameter int ACC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Character stream from the entry text store.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] entry_char
    input  logic        s_axis_tlast,   // last character of the entry

    // One result transaction per entry.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] match, [7:1] zero

    // Register write channel: 0 year, 1 month, 2 day_of_month, 3 hour, 4 minute.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [cetm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cetm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cetm_pkg::*;

    t_cfg  r_cfg;
    logic  w_cfg_wr;

    logic  w_item_valid;
    logic  w_item_ready;
    t_item w_item;
    logic  w_q_valid;
    logic  w_q_pop;
    t_item w_q_item;
    logic [2:0] w_wd;
    logic  w_wd_ok;
    logic  w_match;

    // The register file always accepts writes. Writes to indexes past the
    // minute register are dropped.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.year   <= YEAR_W'(2000);
            r_cfg.month  <= MONTH_W'(1);
            r_cfg.day    <= DAY_W'(1);
            r_cfg.hour   <= '0;
            r_cfg.minute <= '0;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_YEAR:   r_cfg.year   <= i_cfg_data[YEAR_W-1:0];
                CFG_MONTH:  r_cfg.month  <= i_cfg_data[MONTH_W-1:0];
                CFG_DAY:    r_cfg.day    <= i_cfg_data[DAY_W-1:0];
                CFG_HOUR:   r_cfg.hour   <= i_cfg_data[HOUR_W-1:0];
                CFG_MINUTE: r_cfg.minute <= i_cfg_data[MINUTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: classifies each character into a token class and digit.
    cetm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_axis_tvalid),
        .o_s_ready    (s_axis_tready),
        .i_s_char     (s_axis_tdata),
        .i_s_last     (s_axis_tlast),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready),
        .o_item       (w_item)
    );

    // Short queue so the front keeps taking characters while the sequencer
    // is busy with a remainder or waits on the result port.
    cetm_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_item_valid),
        .o_in_ready  (w_item_ready),
        .i_data      (w_item),
        .o_out_valid (w_q_valid),
        .i_pop       (w_q_pop),
        .o_data      (w_q_item)
    );

    // Weekday of the configured date, recomputed after every register write.
    cetm_weekday u_weekday (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_cfg_wr),
        .i_cfg     (r_cfg),
        .o_weekday (w_wd),
        .o_ok      (w_wd_ok)
    );

    // Back end: token scanner, field checks and the result register.
    cetm_back #(
        .ACC_BITS (ACC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_q_valid),
        .o_item_ready (w_q_pop),
        .i_item       (w_q_item),
        .i_cfg        (r_cfg),
        .i_wd         (w_wd),
        .i_wd_ok      (w_wd_ok),
        .o_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .o_m_match    (w_match)
    );

    assign m_axis_tdata = {7'd0, w_match};

endmodule

// File: sim/cron_entry_time_match_unit_tb.sv
module cron_entry_time_match_unit_tb;

    import cetm_pkg::*;

    localparam int ACC_BITS = 16;
    localparam longint unsigned ACC_MAX = (64'd1 << ACC_BITS) - 1;

    // Cycles with no transaction on any channel before the run is declared hung.
    localparam int IDLE_LIMIT = 500;

    // Extra wait after the last owed match bit has been received, with margin.
    localparam int DRAIN_CYCLES = 16;

    // Characters of random entries per configuration phase.
    localparam int PHASE_CHARS = 90;
    localparam int RANDOM_PHASES = 6;

    // Month term of the day-of-week formula, indexed by (month - 1) mod 16.
    localparam int unsigned MONTH_TERM [16] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4,
                                                0, 0, 0, 0};

    // Where the scanner stands inside the current token.
    typedef enum logic [2:0] {
        SC_BETWEEN,
        SC_STAR,
        SC_STAR_SLASH,
        SC_STEP,
        SC_NUM,
        SC_SEP,
        SC_BAD,
        SC_DONE
    } t_scan;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // [7:0] entry_char
    logic                  s_axis_tlast;   // last character of the entry
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;   // [0] match, [7:1] zero
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cron_entry_time_match_unit #(
        .ACC_BITS(ACC_BITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // The date and time the block is configured with, as this bench believes it.
    logic [YEAR_W-1:0]   cfg_year;
    logic [MONTH_W-1:0]  cfg_month;
    logic [DAY_W-1:0]    cfg_day;
    logic [HOUR_W-1:0]   cfg_hour;
    logic [MINUTE_W-1:0] cfg_minute;

    // Scan state of the entry currently being streamed in.
    logic [2:0]        tok_count;
    t_scan             scan;
    longint unsigned   num_acc;
    bit                entry_bad;
    logic [2:0]        wd_latched;

    // Match bits still owed by the block, oldest first.
    bit pending_match [$];

    // Text of the entry being built and sent.
    logic [7:0] txt_q [$];

    bit tx_nogap;
    bit rx_nogap;
    int fail_count;
    int sent_chars;
    int idle_cycles;

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Sakamoto's day-of-week formula on the configured date, 0 = Sunday.
    // The year is shifted by 400 so that year zero and January/February of
    // year zero stay non-negative; the result is unchanged by that shift.
    function automatic logic [2:0] day_of_week();
        int unsigned y;
        int unsigned m;
        int unsigned t;
        m = cfg_month;
        y = cfg_year + 400 - ((m < 3) ? 1 : 0);
        t = MONTH_TERM[(m - 1) & 15];
        return 3'((y + y / 4 - y / 100 + y / 400 + t + cfg_day) % 7);
    endfunction

    // The configured value that the current token is compared against.
    function automatic int unsigned token_value();
        case (tok_count)
            3'd0: return cfg_minute;
            3'd1: return cfg_hour;
            3'd2: return cfg_day;
            3'd3: return cfg_month;
            default: return wd_latched;
        endcase
    endfunction

    function automatic void add_digit(int unsigned d);
        longint unsigned v;
        v = num_acc * 10 + d;
        num_acc = (v > ACC_MAX) ? ACC_MAX : v;
    endfunction

    function automatic void close_token();
        longint unsigned v;
        bit ok;
        v = token_value();
        case (scan)
            SC_STAR, SC_DONE: ok = 1'b1;
            SC_STEP:          ok = (num_acc != 0) && ((v % num_acc) == 0);
            SC_NUM:           ok = (num_acc == v);
            default:          ok = 1'b0;
        endcase
        if (!ok)
            entry_bad = 1'b1;
        if (tok_count < 5)
            tok_count++;
        scan = SC_BETWEEN;
        num_acc = 0;
    endfunction

    function automatic void clear_entry_scan();
        tok_count = 3'd0;
        scan = SC_BETWEEN;
        num_acc = 0;
        entry_bad = 1'b0;
    endfunction

    // Advances the scan by one accepted character. On the character marked
    // last the open token is closed and the match bit is queued.
    function automatic void step_entry_scan(logic [7:0] ch, bit is_last);
        bit ch_is_num;
        int unsigned d;
        ch_is_num = (ch >= CH_ZERO) && (ch <= CH_NINE);
        d = ch_is_num ? int'(ch - CH_ZERO) : 0;

        // The weekday follows the configuration until the first token opens.
        if (tok_count == 0 && scan == SC_BETWEEN)
            wd_latched = day_of_week();

        if (tok_count < 5) begin
            if (ch == CH_SPACE) begin
                if (scan != SC_BETWEEN)
                    close_token();
            end else begin
                case (scan)
                    SC_BETWEEN: begin
                        if (ch == CH_STAR) begin
                            scan = SC_STAR;
                        end else if (ch_is_num) begin
                            scan = SC_NUM;
                            num_acc = d;
                        end else begin
                            scan = SC_BAD;
                        end
                    end
                    SC_STAR: begin
                        scan = (ch == CH_SLASH) ? SC_STAR_SLASH : SC_BAD;
                    end
                    SC_STAR_SLASH: begin
                        if (ch_is_num) begin
                            scan = SC_STEP;
                            num_acc = d;
                        end else begin
                            scan = SC_BAD;
                        end
                    end
                    SC_STEP: begin
                        if (ch_is_num)
                            add_digit(d);
                        else
                            scan = SC_BAD;
                    end
                    SC_NUM: begin
                        // Any non-digit ends a list number; a hit settles the token.
                        if (ch_is_num)
                            add_digit(d);
                        else
                            scan = (num_acc == token_value()) ? SC_DONE : SC_SEP;
                    end
                    SC_SEP: begin
                        if (ch_is_num) begin
                            scan = SC_NUM;
                            num_acc = d;
                        end else begin
                            scan = SC_BAD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (is_last) begin
            if (tok_count < 5 && scan != SC_BETWEEN)
                close_token();
            pending_match.push_back((tok_count == 5) && !entry_bad);
            clear_entry_scan();
        end
    endfunction

    // ------------------------------------------------------------------
    // Entry text generation
    // ------------------------------------------------------------------

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            txt_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] pick_nonspace();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        return (c == CH_SPACE) ? CH_STAR : c;
    endfunction

    // One token aimed at the value it will be compared with, so that matches
    // are common; about a tenth of the tokens are malformed.
    function automatic void gen_token(int unsigned val);
        int unsigned r;
        int unsigned n;
        int unsigned k;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            put_text("*");
        end else if (r < 45) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200000) : $urandom_range(0, 12);
            put_text($sformatf("*/%0d", n));
        end else if (r < 88) begin
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++) begin
                n = ($urandom_range(0, 2) == 0) ? val : $urandom_range(0, 70);
                if ($urandom_range(0, 15) == 0)
                    n = $urandom_range(0, 200000);
                put_text(($urandom_range(0, 4) == 0) ? $sformatf("%03d", n)
                                                      : $sformatf("%0d", n));
                // Separators are mostly commas but may be any byte that is neither a digit
                // nor a space, and now and then one is left dangling at the token end.
                if (i < k - 1 || $urandom_range(0, 5) == 0) begin
                    c = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 2) != 0 || c == CH_SPACE ||
                        (c >= CH_ZERO && c <= CH_NINE))
                        c = ",";
                    txt_q.push_back(c);
                end
            end
        end else begin
            case ($urandom_range(0, 3))
                0: put_text("*/");
                1: put_text($sformatf("*/%0dx", $urandom_range(1, 9)));
                2: begin
                    put_text("*");
                    txt_q.push_back(pick_nonspace());
                end
                default: begin
                    repeat ($urandom_range(1, 3))
                        txt_q.push_back(pick_nonspace());
                end
            endcase
        end
    endfunction

    // Mostly well-formed entries with random content; the rest are wrong
    // token counts, truncated entries and plain noise.
    function automatic void gen_entry();
        int unsigned fv [5];
        int unsigned ntok;
        txt_q.delete();
        fv[0] = cfg_minute;
        fv[1] = cfg_hour;
        fv[2] = cfg_day;
        fv[3] = cfg_month;
        fv[4] = day_of_week();
        if ($urandom_range(0, 9) < 8) begin
            repeat ($urandom_range(0, 2))
                put_text(" ");
            ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 6) : 5;
            for (int f = 0; f < ntok; f++) begin
                if (f > 0) begin
                    repeat ($urandom_range(1, 3))
                        put_text(" ");
                end
                gen_token(fv[(f > 4) ? 4 : f]);
            end
            if ($urandom_range(0, 4) == 0) begin
                put_text(" ");
                repeat ($urandom_range(1, 6))
                    txt_q.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 9) == 0) begin
                while (txt_q.size() > 1 && $urandom_range(0, 3) != 0)
                    void'(txt_q.pop_back());
            end
        end else begin
            repeat ($urandom_range(1, 20))
                txt_q.push_back(($urandom_range(0, 3) == 0) ? CH_SPACE
                                                             : 8'($urandom_range(0, 255)));
        end
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Sends one character and updates the prediction once it is accepted.
    // Valid stays high after the transaction so that a back-to-back character
    // needs no second assignment in the same time step.
    task automatic send_char(input logic [7:0] ch, input bit is_last);
        int gap;
        gap = tx_nogap ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= is_last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        step_entry_scan(ch, is_last);
        sent_chars++;
    endtask

    task automatic send_entry();
        foreach (txt_q[i])
            send_char(txt_q[i], i == txt_q.size() - 1);
    endtask

    task automatic send_text(input string s);
        txt_q.delete();
        put_text(s);
        send_entry();
    endtask

    // Stops the character stream and lets the block run dry. Entries always
    // end in a result, but the drain time is kept anyway in case the block
    // is still finishing internal work after its last result.
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (pending_match.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write; valid is left high for the caller to drop.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_YEAR:   cfg_year   = data[YEAR_W-1:0];
            CFG_MONTH:  cfg_month  = data[MONTH_W-1:0];
            CFG_DAY:    cfg_day    = data[DAY_W-1:0];
            CFG_HOUR:   cfg_hour   = data[HOUR_W-1:0];
            CFG_MINUTE: cfg_minute = data[MINUTE_W-1:0];
            default: begin
            end
        endcase
    endtask

    // Writes all five registers; only called with the block drained.
    task automatic set_date(input logic [CFG_DATA_W-1:0] y, input logic [CFG_DATA_W-1:0] mo,
                            input logic [CFG_DATA_W-1:0] d, input logic [CFG_DATA_W-1:0] h,
                            input logic [CFG_DATA_W-1:0] mi);
        write_reg(CFG_YEAR, y);
        write_reg(CFG_MONTH, mo);
        write_reg(CFG_DAY, d);
        write_reg(CFG_HOUR, h);
        write_reg(CFG_MINUTE, mi);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checking and receiver back-pressure
    // ------------------------------------------------------------------

    function automatic void note_failure(string what);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    // Each accepted result transaction is compared with the oldest owed match
    // bit. The receiver then holds tready low for a freshly drawn number of
    // cycles; the countdown also runs while nothing is offered, so stalls
    // land on every phase of the block's work.
    always @(posedge i_clk) begin : result_side
        int hold;
        bit want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_match.size() == 0) begin
                    note_failure($sformatf("result 0x%02h with no entry outstanding",
                                           m_axis_tdata));
                end else begin
                    want = pending_match.pop_front();
                    if (m_axis_tdata !== {7'd0, want})
                        note_failure($sformatf("match expected %0d, got tdata 0x%02h",
                                               want, m_axis_tdata));
                end
                hold = rx_nogap ? 0 : $urandom_range(0, 6);
            end else if (hold > 0) begin
                hold--;
            end
            m_axis_tready <= (hold == 0);
        end
    end

    // Hang detector: any transaction on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset date is Saturday 2000-01-01 00:00, weekday 6.
    task automatic test_reset_date();
        send_text("* * * * *");
        send_text("0 0 1 1 6");
        send_text("*/5 */1 */1 */1 */3");
        send_text("0,1,2,3,4,5,6 * * * 0,1,2,3,4,5,6");
    endtask

    task automatic test_token_corners();
        send_text("*/0 * * * *");                       // step of zero never matches
        send_text("1,0 0 1 1 6");                        // hit on a later list number
        send_text("0,junk 0 1 1 6");                     // tail after a hit is skipped
        send_text("5, 0 1 1 6");                         // dangling separator, no hit
        send_text("* * * *");                            // too few tokens
        send_text("*/99999999 * * * *");                 // saturated step, 0 mod max
        send_text("0123456789 * * * *");                 // saturated list number
        send_text("*\t* * * *");                         // tab is not a separator
        send_text("   *  *   * * *   extra words 7 x");  // padding and trailing text
        send_text("*/ * * * *");
        send_text("*x * * * *");
        send_text("a * * * *");
        send_text("00 00 01 01 06");
        send_text("* * * * 6");                          // last byte closes the token
        send_text("*");
        send_text(" ");
        // NUL and high bytes are ordinary characters.
        txt_q.delete();
        put_text("*");
        txt_q.push_back(8'h00);
        put_text(" * * * *");
        txt_q.push_back(8'hFF);
        txt_q.push_back(8'h80);
        send_entry();
    endtask

    // Extreme and out-of-range dates, including year zero and odd months.
    task automatic test_date_extremes();
        logic [CFG_DATA_W-1:0] dates [7][5];
        dates = '{'{14'd1, 14'd1, 14'd1, 14'd0, 14'd0},
                  '{14'd9999, 14'd12, 14'd31, 14'd23, 14'd59},
                  '{14'd0, 14'd2, 14'd29, 14'd12, 14'd30},
                  '{14'd0, 14'd0, 14'd0, 14'd0, 14'd0},
                  '{14'd16383, 14'd15, 14'd31, 14'd31, 14'd63},
                  '{14'd2024, 14'd13, 14'd15, 14'd7, 14'd45},
                  '{14'h2AAA, 14'h3FF5, 14'h3FEA, 14'h3FF5, 14'h3FEA}};
        foreach (dates[i]) begin
            quiesce();
            set_date(dates[i][0], dates[i][1], dates[i][2], dates[i][3], dates[i][4]);
            send_text($sformatf("%0d %0d %0d %0d %0d", cfg_minute, cfg_hour, cfg_day,
                                cfg_month, day_of_week()));
            send_text("*/7 */3 */2 */5 */4");
        end
    endtask

    task automatic test_random_entries();
        int phase_start;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            quiesce();
            if ($urandom_range(0, 4) == 0)
                set_date(14'($urandom), 14'($urandom), 14'($urandom), 14'($urandom),
                         14'($urandom));
            else
                set_date(14'($urandom_range(1, 9999)), 14'($urandom_range(1, 12)),
                         14'($urandom_range(1, 31)), 14'($urandom_range(0, 23)),
                         14'($urandom_range(0, 59)));
            phase_start = sent_chars;
            while (sent_chars - phase_start < PHASE_CHARS) begin
                // Roughly one entry in four runs without any idling on a side.
                tx_nogap = ($urandom_range(0, 3) == 0);
                rx_nogap = ($urandom_range(0, 3) == 0);
                gen_entry();
                send_entry();
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tlast  <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_YEAR;
        i_cfg_data    <= '0;
        tx_nogap = 1'b0;
        rx_nogap = 1'b0;
        sent_chars = 0;

        cfg_year   = 14'd2000;
        cfg_month  = 4'd1;
        cfg_day    = 5'd1;
        cfg_hour   = 5'd0;
        cfg_minute = 6'd0;
        clear_entry_scan();
        wd_latched = day_of_week();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_date();
        test_token_corners();
        test_date_extremes();
        test_random_entries();

        quiesce();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/cetm_pkg.sv
sv/cetm_front.sv
sv/cetm_fifo.sv
sv/cetm_weekday.sv
sv/cetm_back.sv
sv/cron_entry_time_match_unit.sv
sim/cron_entry_time_match_unit_tb.sv
